### sv/aabbmp_pkg.sv
// ----------------------------------------------------------------------------
// aabbmp_pkg
// shared constants and types for the box penetration resolve core
// ----------------------------------------------------------------------------
package aabbmp_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int THR_WIDTH   = 16;

    localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd655;

    typedef enum logic [1:0] {
        ACT_BEGIN = 2'b00,
        ACT_TEST  = 2'b01,
        ACT_END   = 2'b10
    } t_action;

    typedef struct packed {
        logic clear_vx;
        logic clear_vy;
        logic grounded;
    } t_flags;

endpackage

### sv/aabb_min_penetration_resolve_core.sv
// ----------------------------------------------------------------------------
// aabb_min_penetration_resolve_core
// pushes one moving box out of a stream of other boxes along the axis of
// least penetration and reports the accumulated position on an end beat
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------
//  in      | to core   | i_in_valid / o_in_stall    | action, box, start pos, flags
//  out     | from core | o_out_valid / i_out_stall  | new pos, velocity flags
//  cfg     | to core   | i_cfg_valid / o_cfg_ready  | penetration threshold
//
//  one beat per cycle sustained while o_in_stall is low; a beat passes through
//  the input register; an end beat's report is loaded into the output register
//  the per-beat state update (penetrations, push select, saturating add)
//  is one combinational pass between the input register and the state
//  reset is synchronous, active low, and clears the entity state to zero
//  a held output stalls the input only when an end beat waits behind it
// ----------------------------------------------------------------------------
module aabb_min_penetration_resolve_core #(
    parameter int COORD_WIDTH = aabbmp_pkg::COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_action,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_pos_y,
    input  logic                          i_is_static,
    input  logic                          i_is_self,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_new_pos_x,
    output logic signed [COORD_WIDTH-1:0] o_new_pos_y,
    output logic                          o_clear_vel_x,
    output logic                          o_clear_vel_y,
    output logic                          o_grounded,
    output logic                          o_untouched,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [aabbmp_pkg::THR_WIDTH-1:0] i_cfg_data
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int SW = COORD_WIDTH + 2;
    localparam int TW = aabbmp_pkg::THR_WIDTH;

    // configuration
    logic [TW-1:0] r_thr;

    // input register
    logic                          r_s1_valid;
    logic [1:0]                    r_s1_action;
    logic signed [COORD_WIDTH-1:0] r_s1_min_x, r_s1_min_y, r_s1_max_x, r_s1_max_y;
    logic signed [COORD_WIDTH-1:0] r_s1_pos_x, r_s1_pos_y;
    logic                          r_s1_static, r_s1_self;

    // entity state
    logic signed [COORD_WIDTH-1:0] r_ent_min_x, r_ent_min_y, r_ent_max_x, r_ent_max_y;
    logic signed [COORD_WIDTH-1:0] r_acc_x, r_acc_y;
    logic                          r_static;
    aabbmp_pkg::t_flags            r_flags;
    logic signed [COORD_WIDTH-1:0] n_acc_x, n_acc_y;
    aabbmp_pkg::t_flags            n_flags;

    // output register
    logic r_out_valid;
    logic signed [COORD_WIDTH-1:0] r_out_x, r_out_y;
    aabbmp_pkg::t_flags            r_out_flags;
    logic                          r_out_untouched;

    logic in_accept, out_free, s1_adv;
    logic s1_begin, s1_test, s1_end;

    logic signed [DW-1:0] rx, lx, ty, by, mx, my, thr, dx, dy;
    logic signed [SW-1:0] sum_x, sum_y;
    logic                 overlap, hit, push_x, push_y;
    logic signed [COORD_WIDTH-1:0] sat_x, sat_y;

    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && (r_s1_action != aabbmp_pkg::ACT_END || out_free);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign s1_begin = s1_adv && (r_s1_action == aabbmp_pkg::ACT_BEGIN);
    assign s1_test  = s1_adv && (r_s1_action == aabbmp_pkg::ACT_TEST);
    assign s1_end   = s1_adv && (r_s1_action == aabbmp_pkg::ACT_END);

    // penetrations against the loaded box
    assign rx = {r_ent_max_x[COORD_WIDTH-1], r_ent_max_x} - {r_s1_min_x[COORD_WIDTH-1], r_s1_min_x};
    assign lx = {r_s1_max_x[COORD_WIDTH-1], r_s1_max_x} - {r_ent_min_x[COORD_WIDTH-1], r_ent_min_x};
    assign ty = {r_ent_max_y[COORD_WIDTH-1], r_ent_max_y} - {r_s1_min_y[COORD_WIDTH-1], r_s1_min_y};
    assign by = {r_s1_max_y[COORD_WIDTH-1], r_s1_max_y} - {r_ent_min_y[COORD_WIDTH-1], r_ent_min_y};

    assign overlap = (rx > 0) && (lx > 0) && (ty > 0) && (by > 0);
    assign hit     = s1_test && !r_static && !r_s1_self && overlap;

    assign mx  = (rx < lx) ? rx : lx;
    assign my  = (ty < by) ? ty : by;
    assign thr = signed'({{(DW-TW){1'b0}}, r_thr});

    assign push_x = hit && (mx < my) && (mx > thr);
    assign push_y = hit && (my <= mx) && (my > thr);

    assign dx = (rx < lx) ? -rx : lx;
    assign dy = (ty < by) ? -ty : by;

    assign sum_x = {{2{r_acc_x[COORD_WIDTH-1]}}, r_acc_x} + {dx[DW-1], dx};
    assign sum_y = {{2{r_acc_y[COORD_WIDTH-1]}}, r_acc_y} + {dy[DW-1], dy};

    // clamp to the signed coordinate range
    always_comb begin
        if (sum_x[SW-1:COORD_WIDTH-1] == {3{1'b0}} || sum_x[SW-1:COORD_WIDTH-1] == {3{1'b1}}) begin
            sat_x = sum_x[COORD_WIDTH-1:0];
        end else if (sum_x[SW-1]) begin
            sat_x = CMIN;
        end else begin
            sat_x = CMAX;
        end
        if (sum_y[SW-1:COORD_WIDTH-1] == {3{1'b0}} || sum_y[SW-1:COORD_WIDTH-1] == {3{1'b1}}) begin
            sat_y = sum_y[COORD_WIDTH-1:0];
        end else if (sum_y[SW-1]) begin
            sat_y = CMIN;
        end else begin
            sat_y = CMAX;
        end
    end

    always_comb begin
        n_acc_x = r_acc_x;
        n_acc_y = r_acc_y;
        n_flags = r_flags;
        if (s1_begin) begin
            n_acc_x = r_s1_pos_x;
            n_acc_y = r_s1_pos_y;
            n_flags = '0;
        end else if (push_x) begin
            n_acc_x          = sat_x;
            n_flags.clear_vx = 1'b1;
        end else if (push_y) begin
            n_acc_y          = sat_y;
            n_flags.clear_vy = 1'b1;
            if (!(ty < by)) begin
                n_flags.grounded = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= aabbmp_pkg::THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_action <= i_action;
            r_s1_min_x  <= i_box_min_x;
            r_s1_min_y  <= i_box_min_y;
            r_s1_max_x  <= i_box_max_x;
            r_s1_max_y  <= i_box_max_y;
            r_s1_pos_x  <= i_start_pos_x;
            r_s1_pos_y  <= i_start_pos_y;
            r_s1_static <= i_is_static;
            r_s1_self   <= i_is_self;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_min_x <= '0;
            r_ent_min_y <= '0;
            r_ent_max_x <= '0;
            r_ent_max_y <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_static    <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (s1_begin) begin
                r_ent_min_x <= r_s1_min_x;
                r_ent_min_y <= r_s1_min_y;
                r_ent_max_x <= r_s1_max_x;
                r_ent_max_y <= r_s1_max_y;
                r_static    <= r_s1_static;
            end
            r_acc_x <= n_acc_x;
            r_acc_y <= n_acc_y;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_end) begin
            r_out_x         <= r_acc_x;
            r_out_y         <= r_acc_y;
            r_out_flags     <= r_static ? '0 : r_flags;
            r_out_untouched <= r_static;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_new_pos_x   = r_out_x;
    assign o_new_pos_y   = r_out_y;
    assign o_clear_vel_x = r_out_flags.clear_vx;
    assign o_clear_vel_y = r_out_flags.clear_vy;
    assign o_grounded    = r_out_flags.grounded;
    assign o_untouched   = r_out_untouched;

    // a new report only follows an end beat leaving the input register
    a_report_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(s1_end))
        else $error("report without end beat");

    // a static entity never moves between begin beats
    a_static_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_static && !s1_begin |=> $stable(r_acc_x) && $stable(r_acc_y))
        else $error("static entity moved");

    // grounded only comes with a y push
    a_ground_with_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_grounded |-> o_clear_vel_y && !o_untouched)
        else $error("grounded without y push");

    // at most one axis pushed per test beat
    a_one_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push_x && push_y))
        else $error("two pushes on one beat");

    // input stalls only behind an end beat blocked by a held report
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_action == aabbmp_pkg::ACT_END && r_out_valid && i_out_stall)
        else $error("unexpected input stall");

endmodule
